### sv/pps_pkg.sv
// Shared types and codes for the PPM stream parser.
package pps_pkg;

   localparam logic [1:0] EV_HEADER = 2'd0;
   localparam logic [1:0] EV_PIXEL  = 2'd1;
   localparam logic [1:0] EV_ERROR  = 2'd2;

   localparam logic [3:0] ERR_MAGIC    = 4'd0;
   localparam logic [3:0] ERR_NO_SPACE = 4'd1;
   localparam logic [3:0] ERR_WIDTH    = 4'd2;
   localparam logic [3:0] ERR_HEIGHT   = 4'd3;
   localparam logic [3:0] ERR_MAXVAL   = 4'd4;
   localparam logic [3:0] ERR_LONG     = 4'd5;
   localparam logic [3:0] ERR_EARLY    = 4'd6;
   localparam logic [3:0] ERR_NEGATIVE = 4'd7;
   localparam logic [3:0] ERR_TOO_BIG  = 4'd8;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef struct packed {
      logic       eos;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  sample;
      logic [11:0] row;
      logic [13:0] col;
      logic        last;
      logic [12:0] width;
      logic [12:0] height;
      logic [15:0] max;
      logic        binary;
      logic [3:0]  err;
   } result_type;

endpackage

### sv/pps_in_stage.sv
// Input register: holds one accepted item until the parser takes it.
module pps_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_data,
   input  logic              req_eos,
   input  logic              take,
   output logic              item_valid,
   output pps_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   pps_pkg::item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.eos  <= req_eos;
         item_ff.data <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/pps_core.sv
// Parser state and single-pass next-state and result logic.
module pps_core #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int MAX_TOKEN_CHARS = 16,
   parameter int WW              = 13,
   parameter int HW              = 13,
   parameter int CW              = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pps_pkg::item_type   item,
   output logic                res_valid,
   output pps_pkg::result_type res
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_MAGIC1   = 4'd1;
   localparam logic [3:0] PH_MAGIC2   = 4'd2;
   localparam logic [3:0] PH_WIDTH    = 4'd3;
   localparam logic [3:0] PH_HEIGHT   = 4'd4;
   localparam logic [3:0] PH_MAXVAL   = 4'd5;
   localparam logic [3:0] PH_SKIPLINE = 4'd6;
   localparam logic [3:0] PH_BINDATA  = 4'd7;
   localparam logic [3:0] PH_ASCDATA  = 4'd8;
   localparam logic [3:0] PH_ERROR    = 4'd9;
   localparam logic [3:0] PH_DONE     = 4'd10;

   logic [3:0]    phase_ff, phase_in;
   logic          bin_ff, bin_in;
   logic [16:0]   tval_ff, tval_in;
   logic [4:0]    tlen_ff, tlen_in;
   logic          tneg_ff, tneg_in;
   logic          cmt_ff, cmt_in;
   logic          tstop_ff, tstop_in;
   logic [WW-1:0] wid_ff, wid_in;
   logic [HW-1:0] hgt_ff, hgt_in;
   logic [15:0]   max_ff, max_in;
   logic [HW-1:0] rows_ff, rows_in;
   logic [CW-1:0] col_ff, col_in;

   logic        c_ws;
   logic        do_fin, fin_nl, do_pix, do_err, pix_last;
   logic [7:0]  pix_s;
   logic [3:0]  err_c;
   logic        fin_neg, fin_big;
   logic [20:0] acc;
   logic [31:0] rowlen32, row32, col_nx32;

   always_comb begin
      c_ws     = item.data inside {[8'h09:8'h0D], 8'h20};
      fin_neg  = tneg_ff && (tval_ff != 17'd0);
      fin_big  = tval_ff > 17'd65535;
      acc      = ({4'd0, tval_ff} << 3) + ({4'd0, tval_ff} << 1)
               + 21'(item.data - pps_pkg::CH_ZERO);
      rowlen32 = (32'(wid_ff) << 1) + 32'(wid_ff);
      row32    = 32'(hgt_ff) - 32'd1 - 32'(rows_ff);
      col_nx32 = 32'(col_ff) + 32'd1;
      pix_last = ((32'(rows_ff) + 32'd1) == 32'(hgt_ff)) && (col_nx32 == rowlen32);

      phase_in = phase_ff;
      bin_in   = bin_ff;
      tval_in  = tval_ff;
      tlen_in  = tlen_ff;
      tneg_in  = tneg_ff;
      cmt_in   = cmt_ff;
      tstop_in = tstop_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      max_in   = max_ff;
      rows_in  = rows_ff;
      col_in   = col_ff;

      res_valid = 1'b0;
      res       = '0;
      do_fin    = 1'b0;
      fin_nl    = 1'b0;
      do_pix    = 1'b0;
      pix_s     = 8'd0;
      do_err    = 1'b0;
      err_c     = pps_pkg::ERR_MAGIC;

      if (fire) begin
         if (item.eos) begin
            if ((phase_ff inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCDATA})
                && (tlen_ff != 5'd0)) begin
               do_fin = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (item.data != pps_pkg::CH_P) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_MAGIC;
                  end else begin
                     phase_in = PH_MAGIC1;
                  end
               end
               PH_MAGIC1: begin
                  if (item.data == pps_pkg::CH_3) begin
                     bin_in   = 1'b0;
                     phase_in = PH_MAGIC2;
                  end else if (item.data == pps_pkg::CH_6) begin
                     bin_in   = 1'b1;
                     phase_in = PH_MAGIC2;
                  end else begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_MAGIC;
                  end
               end
               PH_MAGIC2: begin
                  if (!c_ws) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_NO_SPACE;
                  end else begin
                     phase_in = PH_WIDTH;
                     tval_in  = 17'd0;
                     tlen_in  = 5'd0;
                     tneg_in  = 1'b0;
                     tstop_in = 1'b0;
                     cmt_in   = 1'b0;
                  end
               end
               PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCDATA: begin
                  if (cmt_ff) begin
                     if (item.data == pps_pkg::CH_LF) begin
                        cmt_in = 1'b0;
                        do_fin = tlen_ff != 5'd0;
                        fin_nl = 1'b1;
                     end
                  end else if (item.data == pps_pkg::CH_HASH) begin
                     cmt_in = 1'b1;
                  end else if (c_ws) begin
                     do_fin = tlen_ff != 5'd0;
                     fin_nl = item.data == pps_pkg::CH_LF;
                  end else if ((32'(tlen_ff) + 32'd1) >= 32'(MAX_TOKEN_CHARS)) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_LONG;
                  end else begin
                     if ((tlen_ff == 5'd0) && ((item.data == pps_pkg::CH_MINUS)
                         || (item.data == pps_pkg::CH_PLUS))) begin
                        tneg_in = item.data == pps_pkg::CH_MINUS;
                     end else if ((item.data inside {[8'h30:8'h39]}) && !tstop_ff) begin
                        tval_in = (acc > 21'd65536) ? 17'd65536 : acc[16:0];
                     end else begin
                        tstop_in = 1'b1;
                     end
                     tlen_in = tlen_ff + 5'd1;
                  end
               end
               PH_SKIPLINE: begin
                  if (item.data == pps_pkg::CH_LF) begin
                     phase_in = PH_BINDATA;
                  end
               end
               PH_BINDATA: begin
                  do_pix = 1'b1;
                  pix_s  = item.data;
               end
               default: begin
               end
            endcase
         end

         if (do_fin) begin
            tval_in  = 17'd0;
            tlen_in  = 5'd0;
            tneg_in  = 1'b0;
            tstop_in = 1'b0;
            cmt_in   = 1'b0;
            case (phase_ff)
               PH_WIDTH: begin
                  if (fin_neg || (tval_ff == 17'd0)) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_WIDTH;
                  end else if (fin_big || (32'(tval_ff) > 32'(MAX_WIDTH))) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_TOO_BIG;
                  end else begin
                     wid_in   = tval_ff[WW-1:0];
                     phase_in = PH_HEIGHT;
                  end
               end
               PH_HEIGHT: begin
                  if (fin_neg || (tval_ff == 17'd0)) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_HEIGHT;
                  end else if (fin_big || (32'(tval_ff) > 32'(MAX_HEIGHT))) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_TOO_BIG;
                  end else begin
                     hgt_in   = tval_ff[HW-1:0];
                     phase_in = PH_MAXVAL;
                  end
               end
               PH_MAXVAL: begin
                  if (fin_neg || (tval_ff == 17'd0)) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_MAXVAL;
                  end else if (fin_big) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_TOO_BIG;
                  end else begin
                     max_in = tval_ff[15:0];
                     if (bin_ff) begin
                        phase_in = fin_nl ? PH_BINDATA : PH_SKIPLINE;
                     end else begin
                        phase_in = PH_ASCDATA;
                     end
                     col_in     = '0;
                     rows_in    = '0;
                     res_valid  = 1'b1;
                     res.kind   = pps_pkg::EV_HEADER;
                     res.width  = 13'(32'(wid_ff));
                     res.height = 13'(32'(hgt_ff));
                     res.max    = tval_ff[15:0];
                     res.binary = bin_ff;
                  end
               end
               PH_ASCDATA: begin
                  if (fin_neg) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_NEGATIVE;
                  end else if (fin_big) begin
                     do_err = 1'b1;
                     err_c  = pps_pkg::ERR_TOO_BIG;
                  end else begin
                     do_pix = 1'b1;
                     pix_s  = tval_ff[7:0];
                  end
               end
               default: begin
               end
            endcase
         end

         if (do_pix) begin
            res_valid  = 1'b1;
            res.kind   = pps_pkg::EV_PIXEL;
            res.sample = pix_s;
            res.row    = row32[11:0];
            res.col    = 14'(32'(col_ff));
            res.last   = pix_last;
            res.binary = bin_ff;
            if (col_nx32 >= rowlen32) begin
               col_in  = '0;
               rows_in = rows_ff + HW'(1);
            end else begin
               col_in = col_nx32[CW-1:0];
            end
            if (pix_last) begin
               phase_in = PH_DONE;
            end
         end

         if (do_err) begin
            res_valid = 1'b1;
            res       = '0;
            res.kind  = pps_pkg::EV_ERROR;
            res.err   = err_c;
            phase_in  = PH_ERROR;
            tval_in   = 17'd0;
            tlen_in   = 5'd0;
            tneg_in   = 1'b0;
            tstop_in  = 1'b0;
            cmt_in    = 1'b0;
         end

         if (item.eos) begin
            if (phase_ff inside {PH_IDLE, PH_ERROR, PH_DONE}) begin
               res_valid = 1'b0;
            end else if (!(do_err || (do_pix && pix_last))) begin
               res_valid = 1'b1;
               res       = '0;
               res.kind  = pps_pkg::EV_ERROR;
               res.err   = pps_pkg::ERR_EARLY;
            end
            phase_in = PH_IDLE;
            bin_in   = 1'b0;
            tval_in  = 17'd0;
            tlen_in  = 5'd0;
            tneg_in  = 1'b0;
            cmt_in   = 1'b0;
            tstop_in = 1'b0;
            wid_in   = '0;
            hgt_in   = '0;
            max_in   = 16'd0;
            rows_in  = '0;
            col_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bin_ff   <= 1'b0;
         tval_ff  <= 17'd0;
         tlen_ff  <= 5'd0;
         tneg_ff  <= 1'b0;
         cmt_ff   <= 1'b0;
         tstop_ff <= 1'b0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         max_ff   <= 16'd0;
         rows_ff  <= '0;
         col_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         bin_ff   <= bin_in;
         tval_ff  <= tval_in;
         tlen_ff  <= tlen_in;
         tneg_ff  <= tneg_in;
         cmt_ff   <= cmt_in;
         tstop_ff <= tstop_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         max_ff   <= max_in;
         rows_ff  <= rows_in;
         col_ff   <= col_in;
      end
   end

endmodule

### sv/pps_out_stage.sv
// Result register: holds one result item until the sink takes it.
module pps_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                res_valid,
   input  pps_pkg::result_type res,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output pps_pkg::result_type rsp
);

   logic                valid_ff;
   logic                valid_in;
   pps_pkg::result_type res_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? res_valid : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = res_ff;

endmodule

### sv/ppm_stream_parser.sv
// PPM (P3/P6) byte stream parser, top level.
// One byte item per clock is accepted back to back while the result side keeps up; each item
// passes an input register and one pass of the parser's state update into the result
// register, from which its result is offered on rsp. The single-pass state update (token
// accumulate, row/column count) sets the one-item-per-clock rate. A result held by a stalled
// sink stops the parser, and req_tready drops once the input register holds an item. Each
// item gives at most one result: a header, a pixel byte with its row (numbered from the
// bottom row, which comes last) and byte column, or an error, after which bytes are dropped
// until an item with req_tlast set (end of stream, its data ignored) rearms the parser.
module ppm_stream_parser #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int MAX_TOKEN_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sample_value, row_index, byte_column, image_width, image_height,
   // sample_max, is_binary, error_code, zero pad
   output logic [87:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast    // last_of_image
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(3 * MAX_WIDTH);

   logic                item_valid;
   pps_pkg::item_type   item;
   logic                out_free;
   logic                fire;
   logic                res_valid;
   pps_pkg::result_type res;
   pps_pkg::result_type rsp;

   assign fire = item_valid && out_free;

   pps_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata),
      .req_eos    (req_tlast),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   pps_core #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
      .WW              (WW),
      .HW              (HW),
      .CW              (CW)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   pps_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res_valid  (res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.err, rsp.binary, rsp.max, rsp.height, rsp.width,
                       rsp.col, rsp.row, rsp.sample};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == pps_pkg::EV_PIXEL)
      else $error("last flag on a non-pixel item");

   a_header_maxval: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pps_pkg::EV_HEADER) |-> rsp_tdata[75:60] != 16'd0)
      else $error("header item with zero maxval");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pps_pkg::EV_ERROR) |-> rsp_tdata[76:0] == 77'd0)
      else $error("error item carries pixel or header data");

endmodule

### tb/testbench.sv
// Self-checking testbench for the PPM stream parser: directed table, random image streams.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WIDTH_LIMIT  = 4096;
   localparam int unsigned HEIGHT_LIMIT = 4096;
   localparam int unsigned TOKEN_CHARS  = 16;
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] WS_CHARS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   localparam int unsigned GAP_PCT   [4] = '{0, 58, 0, 10};
   localparam int unsigned STALL_PCT [4] = '{0, 0, 58, 10};

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MAGIC1   = 4'd1;
   localparam logic [3:0] ST_MAGIC2   = 4'd2;
   localparam logic [3:0] ST_WIDTH    = 4'd3;
   localparam logic [3:0] ST_HEIGHT   = 4'd4;
   localparam logic [3:0] ST_MAXVAL   = 4'd5;
   localparam logic [3:0] ST_SKIPLINE = 4'd6;
   localparam logic [3:0] ST_BINDATA  = 4'd7;
   localparam logic [3:0] ST_ASCDATA  = 4'd8;
   localparam logic [3:0] ST_ERROR    = 4'd9;
   localparam logic [3:0] ST_DONE     = 4'd10;

   typedef struct packed {
      pps_pkg::item_type   stim;
      logic                typed;
      logic                fires;
      pps_pkg::result_type ev;
   } step_row_type;

   localparam pps_pkg::result_type NO_EVENT = '0;
   localparam pps_pkg::result_type MAGIC_ERR =
      '{pps_pkg::EV_ERROR, 8'd0, 12'd0, 14'd0, 1'b0, 13'd0, 13'd0, 16'd0, 1'b0,
        pps_pkg::ERR_MAGIC};
   localparam pps_pkg::result_type SPACE_ERR =
      '{pps_pkg::EV_ERROR, 8'd0, 12'd0, 14'd0, 1'b0, 13'd0, 13'd0, 16'd0, 1'b0,
        pps_pkg::ERR_NO_SPACE};
   localparam pps_pkg::result_type EARLY_ERR =
      '{pps_pkg::EV_ERROR, 8'd0, 12'd0, 14'd0, 1'b0, 13'd0, 13'd0, 16'd0, 1'b0,
        pps_pkg::ERR_EARLY};

   localparam step_row_type DIRECTED [25] = '{
      '{'{1'b0, "X"},             1'b1, 1'b1, MAGIC_ERR},
      '{'{1'b1, 8'hFF},           1'b1, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_P},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_3},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, "A"},             1'b1, 1'b1, SPACE_ERR},
      '{'{1'b1, 8'h00},           1'b1, 1'b0, NO_EVENT},
      '{'{1'b1, 8'hFF},           1'b1, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_P},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_3},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_LF},  1'b0, 1'b0, NO_EVENT},
      '{'{1'b1, 8'h5A},           1'b1, 1'b1, EARLY_ERR},
      '{'{1'b0, pps_pkg::CH_P},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_6},   1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, " "},             1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, "1"},             1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, CH_TAB},          1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, "1"},             1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, " "},             1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, "9"},             1'b0, 1'b0, NO_EVENT},
      '{'{1'b0, pps_pkg::CH_LF},  1'b1, 1'b1,
        '{pps_pkg::EV_HEADER, 8'd0, 12'd0, 14'd0, 1'b0, 13'd1, 13'd1, 16'd9, 1'b1, 4'd0}},
      '{'{1'b0, 8'h00},           1'b1, 1'b1,
        '{pps_pkg::EV_PIXEL, 8'h00, 12'd0, 14'd0, 1'b0, 13'd0, 13'd0, 16'd0, 1'b1, 4'd0}},
      '{'{1'b0, 8'hFF},           1'b1, 1'b1,
        '{pps_pkg::EV_PIXEL, 8'hFF, 12'd0, 14'd1, 1'b0, 13'd0, 13'd0, 16'd0, 1'b1, 4'd0}},
      '{'{1'b0, pps_pkg::CH_LF},  1'b1, 1'b1,
        '{pps_pkg::EV_PIXEL, 8'h0A, 12'd0, 14'd2, 1'b1, 13'd0, 13'd0, 16'd0, 1'b1, 4'd0}},
      '{'{1'b1, 8'h00},           1'b1, 1'b0, NO_EVENT},
      '{'{1'b1, 8'hFF},           1'b1, 1'b0, NO_EVENT}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   ppm_stream_parser #(
      .MAX_WIDTH       (WIDTH_LIMIT),
      .MAX_HEIGHT      (HEIGHT_LIMIT),
      .MAX_TOKEN_CHARS (TOKEN_CHARS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // parser shadow state
   logic [3:0]   pstate;
   logic         bin_mode;
   int unsigned  tok_val, tok_len;
   logic         tok_neg, in_cmt, tok_stop;
   int unsigned  img_w, img_h, img_max, rows_seen, col_pos;

   pps_pkg::result_type expected_events [$];
   pps_pkg::item_type   stim_q [$];
   int unsigned  sent_count = 0;
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_gap = 0;
   int unsigned  stall_pct = 0;

   function automatic bit is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void drop_token();
      tok_val = 0;
      tok_len = 0;
      tok_neg = 1'b0;
      tok_stop = 1'b0;
      in_cmt = 1'b0;
   endfunction

   function automatic void clear_parser();
      pstate = ST_IDLE;
      bin_mode = 1'b0;
      drop_token();
      img_w = 0;
      img_h = 0;
      img_max = 0;
      rows_seen = 0;
      col_pos = 0;
   endfunction

   function automatic pps_pkg::result_type error_event(input logic [3:0] code);
      pps_pkg::result_type r;
      r = '0;
      r.kind = pps_pkg::EV_ERROR;
      r.err = code;
      pstate = ST_ERROR;
      drop_token();
      return r;
   endfunction

   function automatic pps_pkg::result_type pixel_event(input logic [7:0] s);
      pps_pkg::result_type r;
      int unsigned row_len;
      int unsigned row;
      logic        lst;
      row_len = img_w * 3;
      row = img_h - 1 - rows_seen;
      lst = (rows_seen + 1 == img_h) && (col_pos + 1 == row_len);
      r = '0;
      r.kind = pps_pkg::EV_PIXEL;
      r.sample = s;
      r.row = row[11:0];
      r.col = col_pos[13:0];
      r.last = lst;
      r.binary = bin_mode;
      col_pos++;
      if (col_pos >= row_len) begin
         col_pos = 0;
         rows_seen++;
      end
      if (lst) pstate = ST_DONE;
      return r;
   endfunction

   function automatic bit close_token(input bit nl, output pps_pkg::result_type r);
      int unsigned v;
      bit          neg, big;
      v = tok_val;
      neg = tok_neg && v != 0;
      big = v > 65535;
      drop_token();
      r = '0;
      case (pstate)
         ST_WIDTH: begin
            if (neg || v == 0) r = error_event(pps_pkg::ERR_WIDTH);
            else if (big || v > WIDTH_LIMIT) r = error_event(pps_pkg::ERR_TOO_BIG);
            else begin
               img_w = v;
               pstate = ST_HEIGHT;
               return 1'b0;
            end
            return 1'b1;
         end
         ST_HEIGHT: begin
            if (neg || v == 0) r = error_event(pps_pkg::ERR_HEIGHT);
            else if (big || v > HEIGHT_LIMIT) r = error_event(pps_pkg::ERR_TOO_BIG);
            else begin
               img_h = v;
               pstate = ST_MAXVAL;
               return 1'b0;
            end
            return 1'b1;
         end
         ST_MAXVAL: begin
            if (neg || v == 0) r = error_event(pps_pkg::ERR_MAXVAL);
            else if (big) r = error_event(pps_pkg::ERR_TOO_BIG);
            else begin
               img_max = v;
               if (!bin_mode) pstate = ST_ASCDATA;
               else if (nl) pstate = ST_BINDATA;
               else pstate = ST_SKIPLINE;
               col_pos = 0;
               rows_seen = 0;
               r.kind = pps_pkg::EV_HEADER;
               r.width = img_w[12:0];
               r.height = img_h[12:0];
               r.max = img_max[15:0];
               r.binary = bin_mode;
            end
            return 1'b1;
         end
         ST_ASCDATA: begin
            if (neg) r = error_event(pps_pkg::ERR_NEGATIVE);
            else if (big) r = error_event(pps_pkg::ERR_TOO_BIG);
            else r = pixel_event(v[7:0]);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit token_char(input logic [7:0] c, output pps_pkg::result_type r);
      r = '0;
      if (in_cmt) begin
         if (c != pps_pkg::CH_LF) return 1'b0;
         in_cmt = 1'b0;
         if (tok_len != 0) return close_token(1'b1, r);
         return 1'b0;
      end
      if (c == pps_pkg::CH_HASH) begin
         in_cmt = 1'b1;
         return 1'b0;
      end
      if (is_space(c)) begin
         if (tok_len != 0) return close_token(c == pps_pkg::CH_LF, r);
         return 1'b0;
      end
      if (tok_len + 1 >= TOKEN_CHARS) begin
         r = error_event(pps_pkg::ERR_LONG);
         return 1'b1;
      end
      if (tok_len == 0 && (c == pps_pkg::CH_MINUS || c == pps_pkg::CH_PLUS)) begin
         tok_neg = (c == pps_pkg::CH_MINUS);
      end else if (c >= pps_pkg::CH_ZERO && c <= pps_pkg::CH_ZERO + 8'd9 && !tok_stop) begin
         tok_val = tok_val * 10 + (c - pps_pkg::CH_ZERO);
         if (tok_val > 65536) tok_val = 65536;
      end else begin
         tok_stop = 1'b1;
      end
      tok_len++;
      return 1'b0;
   endfunction

   // one accepted item -> zero or one parser event
   function automatic bit parse_byte(input pps_pkg::item_type it,
                                     output pps_pkg::result_type r);
      bit got;
      r = '0;
      if (it.eos) begin
         if (pstate == ST_IDLE || pstate == ST_ERROR || pstate == ST_DONE) begin
            clear_parser();
            return 1'b0;
         end
         got = 1'b0;
         if ((pstate == ST_WIDTH || pstate == ST_HEIGHT || pstate == ST_MAXVAL ||
              pstate == ST_ASCDATA) && tok_len != 0)
            got = close_token(1'b0, r);
         if (!(got && (r.kind == pps_pkg::EV_ERROR || pstate == ST_DONE))) begin
            r = error_event(pps_pkg::ERR_EARLY);
            got = 1'b1;
         end
         clear_parser();
         return got;
      end
      case (pstate)
         ST_IDLE: begin
            if (it.data != pps_pkg::CH_P) begin
               r = error_event(pps_pkg::ERR_MAGIC);
               return 1'b1;
            end
            pstate = ST_MAGIC1;
         end
         ST_MAGIC1: begin
            if (it.data == pps_pkg::CH_3) bin_mode = 1'b0;
            else if (it.data == pps_pkg::CH_6) bin_mode = 1'b1;
            else begin
               r = error_event(pps_pkg::ERR_MAGIC);
               return 1'b1;
            end
            pstate = ST_MAGIC2;
         end
         ST_MAGIC2: begin
            if (!is_space(it.data)) begin
               r = error_event(pps_pkg::ERR_NO_SPACE);
               return 1'b1;
            end
            pstate = ST_WIDTH;
            drop_token();
         end
         ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_ASCDATA: return token_char(it.data, r);
         ST_SKIPLINE: if (it.data == pps_pkg::CH_LF) pstate = ST_BINDATA;
         ST_BINDATA: begin
            r = pixel_event(it.data);
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic bit same_event(input pps_pkg::result_type a,
                                     input pps_pkg::result_type b);
      return a.kind === b.kind && a.sample === b.sample && a.row === b.row &&
             a.col === b.col && a.last === b.last && a.width === b.width &&
             a.height === b.height && a.max === b.max && a.binary === b.binary &&
             a.err === b.err;
   endfunction

   function automatic string ev_text(input pps_pkg::result_type r);
      return {$sformatf("kind=%0d sample=%02h row=%0d col=%0d last=%0d",
                        r.kind, r.sample, r.row, r.col, r.last),
              $sformatf(" w=%0d h=%0d max=%0d bin=%0d err=%0d",
                        r.width, r.height, r.max, r.binary, r.err)};
   endfunction

   task automatic check_event();
      pps_pkg::result_type seen, want;
      seen.kind   = rsp_tuser;
      seen.sample = rsp_tdata[7:0];
      seen.row    = rsp_tdata[19:8];
      seen.col    = rsp_tdata[33:20];
      seen.last   = rsp_tlast;
      seen.width  = rsp_tdata[46:34];
      seen.height = rsp_tdata[59:47];
      seen.max    = rsp_tdata[75:60];
      seen.binary = rsp_tdata[76];
      seen.err    = rsp_tdata[80:77];
      if (expected_events.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected event: %s", ev_text(seen));
      end else begin
         want = expected_events.pop_front();
         if (!same_event(seen, want)) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("event mismatch at cycle %0d", cycle_count);
               $display("  expected %s", ev_text(want));
               $display("  actual   %s", ev_text(seen));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) check_event();
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d events outstanding", expected_events.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(input pps_pkg::item_type it, input bit typed,
                            input bit typed_fires, input pps_pkg::result_type typed_ev);
      pps_pkg::result_type ev;
      bit                  fires;
      while ($urandom_range(99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.data;
      req_tlast  <= it.eos;
      do @(posedge clock); while (!req_tready);
      fires = parse_byte(it, ev);
      if (typed) begin
         fires = typed_fires;
         ev = typed_ev;
      end
      if (fires) expected_events.push_back(ev);
      sent_count++;
      send_gap  = GAP_PCT[2'((sent_count / 250) % 4)];
      stall_pct = STALL_PCT[2'((sent_count / 250) % 4)];
   endtask

   task automatic add_byte(input logic [7:0] b);
      pps_pkg::item_type it;
      it.eos = 1'b0;
      it.data = b;
      stim_q.push_back(it);
   endtask

   task automatic add_end();
      pps_pkg::item_type it;
      it.eos = 1'b1;
      it.data = 8'($urandom_range(255));
      stim_q.push_back(it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] no_lf_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == pps_pkg::CH_LF) b = CH_SPACE;
      return b;
   endfunction

   // whitespace run, sometimes a comment
   task automatic add_gap();
      repeat ($urandom_range(1, 2)) begin
         if ($urandom_range(9) == 0) begin
            add_byte(pps_pkg::CH_HASH);
            repeat ($urandom_range(3)) add_byte(no_lf_byte());
            add_byte(pps_pkg::CH_LF);
         end else begin
            add_byte(WS_CHARS[3'($urandom_range(5))]);
         end
      end
   endtask

   // header token text; val is the accepted value, 0 when the token must be rejected
   task automatic pick_field(input int unsigned top, output string txt, output int unsigned val);
      case ($urandom_range(59))
         0: begin txt = "0"; val = 0; end
         1: begin txt = "-2"; val = 0; end
         2: begin txt = $sformatf("%0d", top + 1); val = 0; end
         3: begin txt = "70000"; val = 0; end
         4: begin txt = "0000000000000001"; val = 0; end
         5: begin txt = $sformatf("%0d", top); val = top; end
         6: begin txt = "+2"; val = 2; end
         7: begin txt = "3z9"; val = 3; end
         8: begin txt = "000000000000002"; val = 2; end
         default: begin
            val = $urandom_range(1, 3);
            txt = $sformatf("%0d", val);
         end
      endcase
   endtask

   function automatic string sample_text();
      case ($urandom_range(149))
         0: return "-5";
         1: return "-0";
         2: return "70000";
         3: return "+9";
         4: return "1x2";
         5: return $sformatf("%0d", $urandom_range(256, 65535));
         6: return "65536";
         7: return "0000000000000009";
         8: return "-";
         9: return "-17a";
         default: return $sformatf("%0d", $urandom_range(255));
      endcase
   endfunction

   // one stream: mostly well-formed images, some truncated, some broken magic or noise
   task automatic build_stream();
      string       wtxt, htxt, mtxt;
      int unsigned w, h, m, total, cnt, pick;
      bit          binary, trunc, gapped;
      logic [7:0]  b;
      pick = $urandom_range(99);
      if (pick < 4) begin
         repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
         add_end();
         return;
      end
      add_byte(pps_pkg::CH_P);
      if (pick < 7) begin
         b = 8'($urandom_range(255));
         if (b == pps_pkg::CH_3 || b == pps_pkg::CH_6) b = pps_pkg::CH_P;
         add_byte(b);
         repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
         add_end();
         return;
      end
      binary = 1'($urandom_range(1));
      add_byte(binary ? pps_pkg::CH_6 : pps_pkg::CH_3);
      if (pick < 10) begin
         add_byte(8'($urandom_range(33, 126)));
         add_end();
         return;
      end
      add_byte(WS_CHARS[3'($urandom_range(5))]);
      if ($urandom_range(1)) add_gap();
      pick_field(WIDTH_LIMIT, wtxt, w);
      add_text(wtxt);
      add_gap();
      pick_field(HEIGHT_LIMIT, htxt, h);
      add_text(htxt);
      add_gap();
      pick_field(65535, mtxt, m);
      add_text(mtxt);
      if (w == 0 || h == 0 || m == 0) begin
         repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
         add_end();
         return;
      end
      total = w * h * 3;
      trunc = total > 48 || $urandom_range(9) == 0;
      cnt = trunc ? $urandom_range(total > 20 ? 20 : total - 1) : total;
      gapped = 1'b1;
      if (binary) begin
         case ($urandom_range(9))
            0, 1: begin
               add_byte(CH_SPACE);
               repeat ($urandom_range(3)) add_byte(no_lf_byte());
               add_byte(pps_pkg::CH_LF);
            end
            2: begin
               add_byte(pps_pkg::CH_HASH);
               repeat ($urandom_range(3)) add_byte(no_lf_byte());
               add_byte(pps_pkg::CH_LF);
            end
            3: begin
               add_byte(CH_CR);
               add_byte(pps_pkg::CH_LF);
            end
            default: add_byte(pps_pkg::CH_LF);
         endcase
         repeat (cnt) add_byte(8'($urandom_range(255)));
      end else begin
         add_gap();
         for (int i = 0; i < cnt; i++) begin
            add_text(sample_text());
            gapped = (i + 1 < cnt) || trunc || $urandom_range(2) != 0;
            if (gapped) add_gap();
         end
         if (trunc && $urandom_range(1)) add_text("4");
      end
      if (!trunc && gapped && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
      add_end();
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].fires, DIRECTED[i].ev);
      while (sent_count < RANDOM_ITEMS + 25) begin
         build_stream();
         while (stim_q.size() != 0) send_item(stim_q.pop_front(), 1'b0, 1'b0, NO_EVENT);
      end
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_events.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### ppm_stream_parser.f
sv/pps_pkg.sv
sv/pps_in_stage.sv
sv/pps_core.sv
sv/pps_out_stage.sv
sv/ppm_stream_parser.sv
tb/testbench.sv
